[hw/rtl/lvwfq_pkg.sv]
// Shared types and constants for the line voltage window fault qualifier.
`default_nettype none

package lvwfq_pkg;

	localparam int VOLT_W    = 16;
	localparam int DLY_W     = 16;
	localparam int CNT_W     = 16;
	localparam int NUM_FLT   = 4;
	localparam int NUM_LANES = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	// Fault slots; overvoltage slots come first.
	localparam int FLT_OV_FAST = 0;
	localparam int FLT_OV_SLOW = 1;
	localparam int FLT_UV_FAST = 2;
	localparam int FLT_UV_SLOW = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OV_FAST_TRIP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OV_SLOW_TRIP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UV_FAST_TRIP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UV_SLOW_TRIP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OV_FAST_DELAY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OV_SLOW_DELAY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UV_FAST_DELAY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UV_SLOW_DELAY = 3'd7;

	typedef logic signed [VOLT_W-1:0] volt_t;
	typedef logic signed [VOLT_W:0]   level_t;
	typedef logic [DLY_W-1:0]         delay_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [NUM_FLT-1:0]       flt_vec_t;

	// Per-lane compare result: beyond the trip level, inside the clear level.
	typedef struct packed {
		flt_vec_t beyond;
		flt_vec_t in_clr;
	} lane_flags_t;

	// Per-timer control from the merging stage.
	typedef struct packed {
		logic step;
		logic set_cond;
		logic clr_cond;
		logic clear_all;
	} timer_ctl_t;

	localparam volt_t TRIP_RST [NUM_FLT] = '{16'sd4710, 16'sd4506, 16'sd2048, 16'sd3604};
	localparam delay_t DELAY_RST [NUM_FLT] = '{16'd10, 16'd1000, 16'd10, 16'd2000};

	function automatic logic is_ov(input int f);
		return (f == FLT_OV_FAST) || (f == FLT_OV_SLOW);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/lvwfq_phase_lane.sv]
// One phase lane: compare a phase voltage against every trip and clear level.
`default_nettype none

module lvwfq_phase_lane (
	input  lvwfq_pkg::volt_t       volts,
	input  lvwfq_pkg::volt_t       trip  [lvwfq_pkg::NUM_FLT],
	input  lvwfq_pkg::level_t      clr   [lvwfq_pkg::NUM_FLT],
	output lvwfq_pkg::lane_flags_t flags
);
	import lvwfq_pkg::*;

	level_t volts_x;

	assign volts_x = $signed({volts[VOLT_W-1], volts});

	always_comb begin
		flags = '0;
		for (int f = 0; f < NUM_FLT; f++) begin
			if (is_ov(f)) begin
				flags.beyond[f] = volts > trip[f];
				flags.in_clr[f] = volts_x < clr[f];
			end else begin
				flags.beyond[f] = volts < trip[f];
				flags.in_clr[f] = volts_x > clr[f];
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lvwfq_fault_timer.sv]
// Up/down qualification timer and latch for one fault.
`default_nettype none

module lvwfq_fault_timer #(
	parameter int DOWN_STEP = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lvwfq_pkg::timer_ctl_t  ctl,
	input  lvwfq_pkg::delay_t      delay,
	output logic                   fault,
	output logic                   newly_set
);
	import lvwfq_pkg::*;

	localparam count_t STEP = count_t'(DOWN_STEP);

	count_t cnt_q;
	count_t cnt_d;
	logic   fault_q;
	logic   fault_d;

	always_comb begin
		cnt_d   = cnt_q;
		fault_d = fault_q;
		if (ctl.clear_all) begin
			cnt_d   = '0;
			fault_d = 1'b0;
		end else if (!fault_q) begin
			if (ctl.set_cond) begin
				if (cnt_q < delay) begin
					cnt_d = cnt_q + count_t'(1);
				end else begin
					fault_d = 1'b1;
				end
			end
		end else if (ctl.clr_cond) begin
			if (cnt_q != '0) begin
				cnt_d = (cnt_q > STEP) ? cnt_q - STEP : '0;
			end else begin
				fault_d = 1'b0;
				cnt_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			fault_q <= 1'b0;
		end else if (ctl.step) begin
			cnt_q   <= cnt_d;
			fault_q <= fault_d;
		end
	end

	assign fault     = fault_q;
	assign newly_set = ctl.step && fault_d && !fault_q;

endmodule

`default_nettype wire

[hw/rtl/line_voltage_window_fault_qualifier_core.sv]
// Top level of the three-phase line voltage window fault qualifier.
//
// Input channel (in_valid / in_stall): one item per tick carries the three
// averaged phase voltages and the PLL-enabled flag. Output channel
// (out_valid / out_stall): one result item per input item with the four
// qualified fault latches after this tick's update and a trip_request pulse
// when an overvoltage fault newly set on this tick.
// Configuration: cfg_we writes cfg_data into register cfg_index (trip levels
// 0..3, delays 4..7); write only while no item is in flight.
// Pipeline: three phase lanes compare in parallel, the merge stage ORs the
// trip flags and ANDs the clear flags into s1, then the four fault timers
// update as the item moves into the output register. An accepted item is
// registered in s1 and then in the output register, which raises out_valid;
// one item per cycle is sustained while the output is not stalled.
// Stall: while the output is stalled the s1 stage still takes one more item;
// in_stall rises only when both s1 and the output register are full and the
// output is stalled. A stalled result holds its fields unchanged.
// Reset: arst_n clears the pipeline valids, timers and latches and restores
// the default trip levels and delays.
`default_nettype none

module line_voltage_window_fault_qualifier_core #(
	parameter int HYST_COUNTS     = 205,
	parameter int FAST_CLEAR_STEP = 100
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [lvwfq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lvwfq_pkg::CFG_W-1:0]         cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lvwfq_pkg::VOLT_W-1:0] phase_a_volts,
	input  logic signed [lvwfq_pkg::VOLT_W-1:0] phase_b_volts,
	input  logic signed [lvwfq_pkg::VOLT_W-1:0] phase_c_volts,
	input  logic                                pll_enabled,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ov_fast_fault,
	output logic                                ov_slow_fault,
	output logic                                uv_fast_fault,
	output logic                                uv_slow_fault,
	output logic                                trip_request
);
	import lvwfq_pkg::*;

	localparam level_t HYST = level_t'(HYST_COUNTS);

	// Configuration registers.
	volt_t  trip_q  [NUM_FLT];
	delay_t delay_q [NUM_FLT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trip_q  <= TRIP_RST;
			delay_q <= DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OV_FAST_TRIP:  trip_q[FLT_OV_FAST]  <= volt_t'(cfg_data);
				CFG_OV_SLOW_TRIP:  trip_q[FLT_OV_SLOW]  <= volt_t'(cfg_data);
				CFG_UV_FAST_TRIP:  trip_q[FLT_UV_FAST]  <= volt_t'(cfg_data);
				CFG_UV_SLOW_TRIP:  trip_q[FLT_UV_SLOW]  <= volt_t'(cfg_data);
				CFG_OV_FAST_DELAY: delay_q[FLT_OV_FAST] <= delay_t'(cfg_data);
				CFG_OV_SLOW_DELAY: delay_q[FLT_OV_SLOW] <= delay_t'(cfg_data);
				CFG_UV_FAST_DELAY: delay_q[FLT_UV_FAST] <= delay_t'(cfg_data);
				CFG_UV_SLOW_DELAY: delay_q[FLT_UV_SLOW] <= delay_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// Clear levels at full precision: trip minus hysteresis for OV, plus for UV.
	level_t clr [NUM_FLT];

	always_comb begin
		for (int f = 0; f < NUM_FLT; f++) begin
			if (is_ov(f)) begin
				clr[f] = $signed({trip_q[f][VOLT_W-1], trip_q[f]}) - HYST;
			end else begin
				clr[f] = $signed({trip_q[f][VOLT_W-1], trip_q[f]}) + HYST;
			end
		end
	end

	// Phase lanes.
	volt_t       volts [NUM_LANES];
	lane_flags_t flags [NUM_LANES];

	assign volts[0] = phase_a_volts;
	assign volts[1] = phase_b_volts;
	assign volts[2] = phase_c_volts;

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		lvwfq_phase_lane u_lane (
			.volts (volts[l]),
			.trip  (trip_q),
			.clr   (clr),
			.flags (flags[l])
		);
	end

	// Merge: any phase beyond trips, all phases inside clears.
	flt_vec_t set_d;
	flt_vec_t clr_d;

	always_comb begin
		set_d = '0;
		clr_d = '1;
		for (int l = 0; l < NUM_LANES; l++) begin
			set_d = set_d | flags[l].beyond;
			clr_d = clr_d & flags[l].in_clr;
		end
	end

	// Handshake: advance whenever the output register is free or being taken.
	logic advance;
	logic in_acc;
	logic s1_valid_q;
	logic out_valid_q;
	logic step;

	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = s1_valid_q && !advance;
	assign in_acc   = in_valid && !in_stall;
	assign step     = advance && s1_valid_q;

	flt_vec_t set_s1;
	flt_vec_t clr_s1;
	logic     pll_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!s1_valid_q || advance) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			set_s1 <= set_d;
			clr_s1 <= clr_d;
			pll_s1 <= pll_enabled;
		end
	end

	// Fault timers; they update as the item enters the output register.
	timer_ctl_t ctl   [NUM_FLT];
	flt_vec_t   fault;
	flt_vec_t   newly;

	always_comb begin
		for (int f = 0; f < NUM_FLT; f++) begin
			ctl[f].step      = step;
			ctl[f].set_cond  = set_s1[f];
			ctl[f].clr_cond  = clr_s1[f];
			ctl[f].clear_all = !is_ov(f) && !pll_s1;
		end
	end

	for (genvar f = 0; f < NUM_FLT; f++) begin : g_timer
		lvwfq_fault_timer #(
			.DOWN_STEP ((f == FLT_UV_SLOW) ? FAST_CLEAR_STEP : 1)
		) u_timer (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[f]),
			.delay     (delay_q[f]),
			.fault     (fault[f]),
			.newly_set (newly[f])
		);
	end

	// Output register; the fault latches themselves hold the fault fields.
	logic trip_req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			trip_req_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
			trip_req_q  <= newly[FLT_OV_FAST] || newly[FLT_OV_SLOW];
		end
	end

	assign out_valid     = out_valid_q;
	assign ov_fast_fault = fault[FLT_OV_FAST];
	assign ov_slow_fault = fault[FLT_OV_SLOW];
	assign uv_fast_fault = fault[FLT_UV_FAST];
	assign uv_slow_fault = fault[FLT_UV_SLOW];
	assign trip_request  = trip_req_q;

	// A trip request always comes with a set overvoltage fault.
	a_trip_has_fault: assert property (@(posedge clk) disable iff (!arst_n)
		trip_request |-> (ov_fast_fault || ov_slow_fault))
		else $error("trip_request without an overvoltage fault");

	// No trip pulse outside a valid result.
	a_trip_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !trip_request)
		else $error("trip_request while out_valid is low");

	// PLL disabled clears both undervoltage faults.
	a_pll_off_clears_uv: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !pll_s1) |=> (!uv_fast_fault && !uv_slow_fault))
		else $error("undervoltage fault survived PLL disable");

	// Input is held off only when both stages are occupied.
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q))
		else $error("in_stall with a free pipeline stage");

endmodule

`default_nettype wire
